// ----- sv/histogram_chunk_loader_defines.svh -----
// assertion macros used by the checker file
`ifndef HISTOGRAM_CHUNK_LOADER_DEFINES_SVH
`define HISTOGRAM_CHUNK_LOADER_DEFINES_SVH

// property must hold at every edge outside reset
`define HCL_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define HCL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/hcl_pkg.sv -----
package hcl_pkg;

  localparam logic [1:0] CMD_BYTE  = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  // byte count from which a finished chunk publishes its total
  localparam logic [2:0] MIN_CHUNK = 3'd6;

  typedef enum logic [1:0] {
    OP_NOP,
    OP_WRITE,
    OP_READ,
    OP_CLEAR
  } op_kind_e;

  typedef struct packed {
    op_kind_e    kind;
    logic        publish;
    logic [15:0] addr;
    logic [31:0] word;
  } hcl_op_t;

endpackage

// ----- sv/hcl_front.sv -----
module hcl_front #(
  parameter int CHANNELS = 8192
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  input  logic           ready_i,
  input  logic [1:0]     cmd_i,
  input  logic [7:0]     data_byte_i,
  input  logic           last_byte_i,
  input  logic [15:0]    bin_index_i,
  output logic           push_o,
  output hcl_pkg::hcl_op_t op_o
);
  import hcl_pkg::*;

  localparam logic [16:0] ChanLimit = 17'(CHANNELS);

  logic [2:0]  cnt_q, cnt_d;
  logic [1:0]  lane_q, lane_d;
  logic [7:0]  lo_q, lo_d;
  logic [16:0] ptr_q, ptr_d;
  logic [23:0] asm_q, asm_d;

  assign push_o = valid_i && ready_i;

  always_comb begin
    cnt_d        = cnt_q;
    lane_d       = lane_q;
    lo_d         = lo_q;
    ptr_d        = ptr_q;
    asm_d        = asm_q;
    op_o.kind    = OP_NOP;
    op_o.publish = 1'b0;
    op_o.addr    = bin_index_i;
    op_o.word    = {data_byte_i, asm_q};
    if (push_o) begin
      unique case (cmd_i)
        CMD_BYTE: begin
          if (cnt_q == 3'd0) begin
            lo_d = data_byte_i;
          end else if (cnt_q == 3'd1) begin
            ptr_d = {1'b0, data_byte_i, lo_q};
          end else begin
            if (lane_q == 2'd3) begin
              if (ptr_q < ChanLimit) begin
                op_o.kind = OP_WRITE;
                op_o.addr = ptr_q[15:0];
              end
              // bit 16 set means past every bin, hold there
              ptr_d = ptr_q[16] ? ptr_q : ptr_q + 17'd1;
            end else begin
              asm_d[{lane_q, 3'b000} +: 8] = data_byte_i;
            end
            lane_d = lane_q + 2'd1;
          end
          cnt_d = (cnt_q == 3'd7) ? cnt_q : cnt_q + 3'd1;
          if (last_byte_i) begin
            op_o.publish = (cnt_d >= MIN_CHUNK);
            cnt_d        = 3'd0;
            lane_d       = 2'd0;
            asm_d        = 24'd0;
          end
        end
        CMD_READ: begin
          if ({1'b0, bin_index_i} < ChanLimit) begin
            op_o.kind = OP_READ;
          end
        end
        CMD_CLEAR: begin
          op_o.kind = OP_CLEAR;
        end
        default: begin
          op_o.kind = OP_NOP;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= 3'd0;
      lane_q <= 2'd0;
      lo_q   <= 8'd0;
      ptr_q  <= 17'd0;
      asm_q  <= 24'd0;
    end else begin
      cnt_q  <= cnt_d;
      lane_q <= lane_d;
      lo_q   <= lo_d;
      ptr_q  <= ptr_d;
      asm_q  <= asm_d;
    end
  end

endmodule

// ----- sv/hcl_fifo.sv -----
module hcl_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  hcl_pkg::hcl_op_t op_i,
  input  logic             pop_i,
  output logic             full_o,
  output logic             valid_o,
  output hcl_pkg::hcl_op_t op_o
);
  import hcl_pkg::*;

  hcl_op_t    slot_q [2];
  logic       wr_q, wr_d;
  logic       rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign op_o    = slot_q[rd_q];

  always_comb begin
    wr_d  = push_i ? ~wr_q : wr_q;
    rd_d  = pop_i ? ~rd_q : rd_q;
    cnt_d = cnt_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= op_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// ----- sv/hcl_back.sv -----
module hcl_back #(
  parameter int CHANNELS = 8192
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             op_valid_i,
  input  hcl_pkg::hcl_op_t op_i,
  output logic             op_pop_o,
  output logic             init_busy_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [31:0]      read_value_o,
  output logic [31:0]      spec_total_o,
  output logic             spectrum_valid_o
);
  import hcl_pkg::*;

  localparam int AW = $clog2(CHANNELS);
  localparam logic [AW-1:0] LastBin = AW'(CHANNELS - 1);

  localparam logic [2:0] S_INIT = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_EXEC = 3'd2;
  localparam logic [2:0] S_SUM  = 3'd3;
  localparam logic [2:0] S_CLR  = 3'd4;
  localparam logic [2:0] S_RESP = 3'd5;

  logic [31:0] mem [CHANNELS];
  logic [31:0] rdata_q;

  logic [2:0]    state_q, state_d;
  logic [AW-1:0] clr_q, clr_d;
  logic [31:0]   sum_q, sum_d;
  logic [31:0]   total_q, total_d;
  logic          flag_q, flag_d;
  hcl_op_t       op_q, op_d;
  logic [31:0]   delta_q, delta_d;
  logic [31:0]   rd_q, rd_d;
  logic          out_v_q, out_v_d;
  logic [31:0]   out_rd_q, out_rd_d;
  logic [31:0]   out_tot_q, out_tot_d;
  logic          out_flag_q, out_flag_d;

  logic          we, re;
  logic [AW-1:0] wa, ra;
  logic [31:0]   wd;

  assign init_busy_o      = (state_q == S_INIT);
  assign out_valid_o      = out_v_q;
  assign read_value_o     = out_rd_q;
  assign spec_total_o     = out_tot_q;
  assign spectrum_valid_o = out_flag_q;

  always_comb begin
    state_d    = state_q;
    clr_d      = clr_q;
    sum_d      = sum_q;
    total_d    = total_q;
    flag_d     = flag_q;
    op_d       = op_q;
    delta_d    = delta_q;
    rd_d       = rd_q;
    out_v_d    = out_v_q && !out_ready_i;
    out_rd_d   = out_rd_q;
    out_tot_d  = out_tot_q;
    out_flag_d = out_flag_q;
    op_pop_o   = 1'b0;
    we         = 1'b0;
    re         = 1'b0;
    wa         = clr_q;
    wd         = 32'd0;
    ra         = op_i.addr[AW-1:0];
    unique case (state_q)
      S_INIT: begin
        we    = 1'b1;
        clr_d = clr_q + AW'(1);
        if (clr_q == LastBin) begin
          clr_d   = '0;
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (op_valid_i) begin
          op_pop_o = 1'b1;
          op_d     = op_i;
          re       = 1'b1;
          if (op_i.kind == OP_CLEAR) begin
            sum_d   = 32'd0;
            total_d = 32'd0;
            flag_d  = 1'b0;
            state_d = S_CLR;
          end else begin
            state_d = S_EXEC;
          end
        end
      end
      S_EXEC: begin
        rd_d    = 32'd0;
        state_d = S_RESP;
        unique case (op_q.kind)
          OP_WRITE: begin
            // old value came back from the read issued on pop
            we      = 1'b1;
            wa      = op_q.addr[AW-1:0];
            wd      = op_q.word;
            delta_d = op_q.word - rdata_q;
            state_d = S_SUM;
          end
          OP_READ: begin
            rd_d = rdata_q;
          end
          OP_NOP: begin
            if (op_q.publish) begin
              total_d = sum_q;
              flag_d  = 1'b1;
            end
          end
          OP_CLEAR: begin
            rd_d = 32'd0;
          end
        endcase
      end
      S_SUM: begin
        sum_d = sum_q + delta_q;
        if (op_q.publish) begin
          total_d = sum_d;
          flag_d  = 1'b1;
        end
        state_d = S_RESP;
      end
      S_CLR: begin
        we    = 1'b1;
        clr_d = clr_q + AW'(1);
        rd_d  = 32'd0;
        if (clr_q == LastBin) begin
          clr_d   = '0;
          state_d = S_RESP;
        end
      end
      S_RESP: begin
        if (!out_v_q || out_ready_i) begin
          out_v_d    = 1'b1;
          out_rd_d   = rd_q;
          out_tot_d  = total_q;
          out_flag_d = flag_q;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rdata_q <= mem[ra];
    end
  end

  always_ff @(posedge clk_i) begin
    op_d_reg: begin
      op_q       <= op_d;
      delta_q    <= delta_d;
      rd_q       <= rd_d;
      out_rd_q   <= out_rd_d;
      out_tot_q  <= out_tot_d;
      out_flag_q <= out_flag_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
      clr_q   <= '0;
      sum_q   <= 32'd0;
      total_q <= 32'd0;
      flag_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      sum_q   <= sum_d;
      total_q <= total_d;
      flag_q  <= flag_d;
      out_v_q <= out_v_d;
    end
  end

endmodule

// ----- sv/histogram_chunk_loader.sv -----
// channel  dir  tdata (low bit up)                      tuser           tlast
// s_axis   in   data_byte[7:0], bin_index[23:8]         cmd[1:0]        last_byte
// m_axis   out  read_value[31:0], spec_total[63:32]     spectrum_valid  -
//
// in the back end a chunk byte or a read passes S_IDLE, S_EXEC and S_RESP,
// a bin write passes S_IDLE, S_EXEC, S_SUM and S_RESP (read old count,
// write, update sum, respond); a clear walks the bin memory, zeroing it
// after reset the memory is swept to zero with s_axis_tready low
// a two-entry request queue lets the parser keep taking bytes while the back
// end writes, clears or waits on m_axis_tready
module histogram_chunk_loader #(
  parameter int CHANNELS = 8192
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // data_byte[7:0], bin_index[23:8]
  input  logic        s_axis_tlast,
  input  logic [1:0]  s_axis_tuser,   // cmd[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // read_value[31:0], spec_total[63:32]
  output logic        m_axis_tuser    // spectrum_valid
);
  import hcl_pkg::*;

  logic    push, fifo_full, fifo_valid, pop, init_busy;
  hcl_op_t push_op, head_op;
  logic [31:0] read_value, spec_total;

  assign s_axis_tready = !fifo_full && !init_busy;
  assign m_axis_tdata  = {spec_total, read_value};

  hcl_front #(
    .CHANNELS (CHANNELS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (s_axis_tvalid),
    .ready_i     (s_axis_tready),
    .cmd_i       (s_axis_tuser),
    .data_byte_i (s_axis_tdata[7:0]),
    .last_byte_i (s_axis_tlast),
    .bin_index_i (s_axis_tdata[23:8]),
    .push_o      (push),
    .op_o        (push_op)
  );

  hcl_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .op_i    (push_op),
    .pop_i   (pop),
    .full_o  (fifo_full),
    .valid_o (fifo_valid),
    .op_o    (head_op)
  );

  hcl_back #(
    .CHANNELS (CHANNELS)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .op_valid_i       (fifo_valid),
    .op_i             (head_op),
    .op_pop_o         (pop),
    .init_busy_o      (init_busy),
    .out_valid_o      (m_axis_tvalid),
    .out_ready_i      (m_axis_tready),
    .read_value_o     (read_value),
    .spec_total_o     (spec_total),
    .spectrum_valid_o (m_axis_tuser)
  );

endmodule

// ----- sv/hcl_checker.sv -----
`include "histogram_chunk_loader_defines.svh"

module hcl_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [23:0] s_axis_tdata,
  input logic        s_axis_tlast,
  input logic [1:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  logic       in_acc, out_acc;
  logic [7:0] pend_q, pend_d;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;

  // requests taken but not yet answered
  always_comb begin
    pend_d = pend_q + {7'd0, in_acc} - {7'd0, out_acc};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 8'd0;
    end else begin
      pend_q <= pend_d;
    end
  end

  `HCL_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled response changed")
  `HCL_ASSERT(a_total_zero, clk_i, rst_ni, m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[63:32] == 32'd0, "total nonzero while spectrum not valid")
  `HCL_ASSERT(a_no_extra, clk_i, rst_ni, m_axis_tvalid |-> pend_q != 8'd0, "response without a pending request")
  `HCL_ASSERT(a_pend_bound, clk_i, rst_ni, pend_q <= 8'd4, "more requests in flight than queue and stages hold")

endmodule

bind histogram_chunk_loader hcl_checker u_hcl_checker (.*);

// ----- sim/tb_histogram_chunk_loader.sv -----
module tb_histogram_chunk_loader;
  timeunit 1ns;
  timeprecision 1ps;

  import hcl_pkg::*;

  localparam int          N_BINS     = 8192;
  localparam int          N_ITEMS    = 1900;
  localparam logic [1:0]  CMD_UNUSED = 2'd3;

  typedef struct {
    bit [31:0] read_value;
    bit [31:0] total;
    bit        valid;
  } hist_result_t;

  // tracks the spectrum and holds the responses still owed by the block
  class spectrum_tracker;
    bit [31:0]    counts[N_BINS];
    bit [31:0]    run_sum;
    bit [31:0]    pub_total;
    bit           pub_valid;
    int unsigned  byte_cnt;
    int unsigned  start;
    bit [23:0]    partial;
    hist_result_t due[$];
    int           errors;

    function void clear_spectrum();
      foreach (counts[i]) counts[i] = '0;
      run_sum   = '0;
      pub_total = '0;
      pub_valid = 1'b0;
    endfunction

    function void take_byte(bit [7:0] b, bit is_last);
      int unsigned rel;
      int unsigned bin;
      bit [31:0]   word;
      if (byte_cnt == 0) begin
        start = b;
      end else if (byte_cnt == 1) begin
        start = start | (int'(b) << 8);
      end else begin
        rel = byte_cnt - 2;
        if (rel[1:0] == 2'd3) begin
          word = {b, partial};
          bin  = start + (rel >> 2);
          if (bin < N_BINS) begin
            run_sum     = run_sum - counts[bin] + word;
            counts[bin] = word;
          end
          partial = '0;
        end else if (rel[1:0] == 2'd0) begin
          partial = {16'h0, b};
        end else begin
          partial[rel[1:0]*8 +: 8] = b;
        end
      end
      if (byte_cnt != 32'hFFFF_FFFF) byte_cnt++;
      if (is_last) begin
        if (byte_cnt >= MIN_CHUNK) begin
          pub_total = run_sum;
          pub_valid = 1'b1;
        end
        byte_cnt = 0;
        start    = 0;
        partial  = '0;
      end
    endfunction

    function void note_request(logic [1:0] cmd, logic [7:0] data, logic is_last,
                               logic [15:0] idx);
      hist_result_t res;
      res.read_value = '0;
      case (cmd)
        CMD_BYTE:  take_byte(data, is_last);
        CMD_READ:  if (idx < N_BINS) res.read_value = counts[idx];
        CMD_CLEAR: clear_spectrum();
        default:   ;
      endcase
      res.total = pub_total;
      res.valid = pub_valid;
      due.push_back(res);
    endfunction

    function void check_result(logic [31:0] rd, logic [31:0] tot, logic vld);
      hist_result_t exp_res;
      if (due.size() == 0) begin
        $display("%0t ns: response with none outstanding (read %h total %h valid %b)",
                 $time, rd, tot, vld);
        errors++;
        return;
      end
      exp_res = due.pop_front();
      if (rd !== exp_res.read_value) begin
        $display("%0t ns: read_value expected %h got %h", $time, exp_res.read_value, rd);
        errors++;
      end
      if (tot !== exp_res.total) begin
        $display("%0t ns: spec_total expected %h got %h", $time, exp_res.total, tot);
        errors++;
      end
      if (vld !== exp_res.valid) begin
        $display("%0t ns: spectrum_valid expected %b got %b", $time, exp_res.valid, vld);
        errors++;
      end
    endfunction

    function int pending();
      return due.size();
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;
  logic        s_axis_tlast;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [63:0] m_axis_tdata;
  logic        m_axis_tuser;

  spectrum_tracker tracker = new();
  int unsigned     items_sent;
  bit              send_gaps_on  = 1'b1;
  bit              sink_stalls_on = 1'b1;
  int              hold_cycles;

  histogram_chunk_loader #(
    .CHANNELS(N_BINS)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #15ms;
    $display("tb_histogram_chunk_loader: FAIL");
    $finish;
  end

  // response side: random stall bursts plus one long hold-off on request
  initial begin
    int stall_left;
    stall_left    = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_cycles > 0) begin
        m_axis_tready <= 1'b0;
        hold_cycles--;
      end else if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else if (sink_stalls_on && $urandom_range(0, 7) == 0) begin
        m_axis_tready <= 1'b0;
        stall_left = $urandom_range(0, 6);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      tracker.check_result(m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tuser);
    end
  end

  task automatic send_req(input logic [1:0] cmd, input logic [7:0] data,
                          input logic is_last, input logic [15:0] idx);
    int gap;
    if (send_gaps_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 7);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {idx, data};
    s_axis_tlast  <= is_last;
    do @(posedge clk_i); while (!s_axis_tready);
    tracker.note_request(cmd, data, is_last, idx);
    items_sent++;
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (tracker.pending() != 0);
  endtask

  function automatic logic [15:0] pick_read_bin();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 16'($urandom_range(0, 70));
    if (r < 75) return 16'($urandom_range(N_BINS - 12, N_BINS + 8));
    return 16'($urandom_range(0, 65535));
  endfunction

  function automatic int unsigned pick_start_bin();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(0, 48);
    if (r < 80) return $urandom_range(N_BINS - 12, N_BINS - 1);
    if (r < 90) return $urandom_range(0, 65535);
    return $urandom_range(65528, 65535);
  endfunction

  task automatic send_misc();
    int r;
    r = $urandom_range(0, 99);
    if (r < 92) begin
      send_req(CMD_READ, 8'($urandom), 1'($urandom), pick_read_bin());
    end else if (r < 97) begin
      send_req(CMD_UNUSED, 8'($urandom), 1'($urandom), 16'($urandom));
    end else begin
      send_req(CMD_CLEAR, 8'($urandom), 1'($urandom), 16'($urandom));
    end
  endtask

  // cut > 0 truncates the chunk to that many bytes (broken sequence)
  task automatic send_chunk(input int unsigned first_bin, input int groups,
                            input int tail, input int cut);
    logic [7:0] bytes[$];
    logic [31:0] word;
    int          r;
    bytes.push_back(first_bin[7:0]);
    bytes.push_back(first_bin[15:8]);
    for (int g = 0; g < groups; g++) begin
      r = $urandom_range(0, 9);
      word = (r < 2) ? 32'hFFFF_FFFF : (r < 3) ? 32'h0 : 32'($urandom);
      for (int k = 0; k < 4; k++) bytes.push_back(word[k*8 +: 8]);
    end
    for (int k = 0; k < tail; k++) bytes.push_back(8'($urandom));
    while (cut > 0 && bytes.size() > cut) void'(bytes.pop_back());
    foreach (bytes[i]) begin
      if ($urandom_range(0, 9) == 0) send_misc();
      send_req(CMD_BYTE, bytes[i], i == bytes.size() - 1, 16'($urandom));
    end
  endtask

  initial begin
    int  r;
    bit  held;
    bit  drained;
    held          = 1'b0;
    drained       = 1'b0;
    items_sent    = 0;
    hold_cycles   = 0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    s_axis_tuser  = CMD_BYTE;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty reads, unused command, chunk across the top bin
    send_req(CMD_READ, 8'h00, 1'b0, 16'h0000);
    send_req(CMD_READ, 8'hFF, 1'b1, 16'hFFFF);
    send_req(CMD_UNUSED, 8'hFF, 1'b1, 16'hFFFF);
    send_req(CMD_BYTE, 8'hFF, 1'b0, 16'h0000);
    send_req(CMD_BYTE, 8'h1F, 1'b0, 16'hFFFF);
    repeat (4) send_req(CMD_BYTE, 8'hFF, 1'b0, 16'h0000);
    send_req(CMD_READ, 8'h00, 1'b1, 16'(N_BINS - 1));
    send_req(CMD_BYTE, 8'h01, 1'b0, 16'h0000);
    send_req(CMD_BYTE, 8'h02, 1'b0, 16'h0000);
    send_req(CMD_BYTE, 8'h03, 1'b0, 16'h0000);
    send_req(CMD_BYTE, 8'h04, 1'b0, 16'h0000);
    // trailing partial group is dropped
    send_req(CMD_BYTE, 8'hAA, 1'b0, 16'h0000);
    send_req(CMD_BYTE, 8'h55, 1'b1, 16'h0000);
    send_req(CMD_READ, 8'h00, 1'b0, 16'(N_BINS - 1));
    send_req(CMD_READ, 8'h00, 1'b0, 16'(N_BINS));
    // five bytes: too short to publish
    send_req(CMD_BYTE, 8'h00, 1'b0, 16'h0000);
    send_req(CMD_BYTE, 8'h00, 1'b0, 16'h0000);
    send_req(CMD_BYTE, 8'hFF, 1'b0, 16'h0000);
    send_req(CMD_BYTE, 8'hFF, 1'b0, 16'h0000);
    send_req(CMD_BYTE, 8'hFF, 1'b1, 16'h0000);
    send_req(CMD_CLEAR, 8'hFF, 1'b1, 16'hFFFF);
    send_req(CMD_READ, 8'h00, 1'b0, 16'(N_BINS - 1));

    while (items_sent < N_ITEMS) begin
      if (!held && items_sent >= 200) begin
        // long output hold-off while requests keep coming
        hold_cycles = 400;
        held = 1'b1;
      end
      if (!drained && items_sent >= 1000) begin
        wait_drained();
        drained = 1'b1;
      end
      if (items_sent >= N_ITEMS - 200) begin
        send_gaps_on   = 1'b0;
        sink_stalls_on = 1'b0;
      end
      r = $urandom_range(0, 99);
      if (r < 60) begin
        send_chunk(pick_start_bin(), $urandom_range(0, 6),
                   ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0, 0);
      end else if (r < 88) begin
        send_misc();
      end else if (r < 89) begin
        send_req(CMD_CLEAR, 8'($urandom), 1'($urandom), 16'($urandom));
      end else begin
        send_chunk(pick_start_bin(), $urandom_range(0, 2), $urandom_range(0, 3),
                   $urandom_range(1, 8));
      end
    end

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("tb_histogram_chunk_loader: PASS");
    end else begin
      if (tracker.pending() != 0) begin
        $display("%0t ns: %0d responses never arrived", $time, tracker.pending());
      end
      $display("tb_histogram_chunk_loader: FAIL");
    end
    $finish;
  end

endmodule
